FILE: hw/rtl/dnb_pkg.sv
// ----------------------------------------------------------------------------
// dnb_pkg
// Shared types and helpers of the direct-summation gravity core.
// ----------------------------------------------------------------------------
package dnb_pkg;

  typedef enum logic [3:0] {
    P_IDLE, P_SUB, P_SQ, P_R, P_NORM, P_SQRT, P_DIV, P_MUL,
    P_FLO, P_FHI, P_FADD, P_FSH, P_POT, P_DONE
  } dnb_pair_state_t;

  typedef enum logic [3:0] {
    T_LOAD, T_ROW_RD, T_ROW_LAT, T_PAIR_RD, T_PAIR_GO, T_PAIR_WAIT,
    T_PAIR_WB, T_ROW_WB, T_OUT_RD, T_OUT_LAT, T_OUT_SEND
  } dnb_top_state_t;

  typedef struct packed {
    logic            skip;
    logic [63:0]     pot_i;
    logic [63:0]     pot_j;
    logic [2:0][63:0] acc_i;
    logic [2:0][63:0] acc_j;
  } dnb_pair_res_t;

  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? SAT_MIN : SAT_MAX;
    end
    return s;
  endfunction

endpackage

FILE: hw/rtl/dnb_ram.sv
// ----------------------------------------------------------------------------
// dnb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dnb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/dnb_pair.sv
// ----------------------------------------------------------------------------
// dnb_pair
// Multi-cycle evaluation of one particle pair: softened distance, iterative
// square root and reciprocal, then potential and force terms for both sides
// on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module dnb_pair
  import dnb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0][31:0] pos_i,
  input  logic [31:0]      mass_i,
  input  logic [2:0][31:0] pos_j,
  input  logic [31:0]      mass_j,
  input  logic [31:0]      eps2,
  output logic             done,
  output dnb_pair_res_t    res
);

  dnb_pair_state_t state, state_next;
  logic [4:0]  cnt;
  logic [2:0]  fc;
  logic [2:0][31:0] pi, pj, ad;
  logic [2:0]  neg;
  logic [31:0] mi, mj, eps;
  logic [65:0] sum;
  logic [63:0] r, num, root, bitv;
  logic [4:0]  h;
  logic [31:0] rem, q, t, u;
  logic [63:0] pr_i, pr_j, au_i, au_j, p0, p1;
  logic [95:0] prod;
  logic        skip;
  logic [63:0] pot_i, pot_j;
  logic [2:0][63:0] acc_i, acc_j;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;
  logic [63:0]  r_calc;
  logic [64:0]  rb;
  logic [32:0]  rem2;
  logic [63:0]  fa;
  logic [1:0]   fcc;
  logic [6:0]   shf;
  logic [108:0] fv;
  logic [63:0]  mag;
  logic [5:0]   shp;
  logic [32:0]  ds [3];

  assign r_calc = sum[65:2] + {18'd0, eps, 14'd0};
  assign rb     = {1'b0, root} + {1'b0, bitv};
  assign rem2   = {rem, 1'b1};
  assign fa     = fc[0] ? au_i : au_j;
  assign fcc    = fc[2:1];
  assign shf    = 7'd93 - ({1'b0, h, 1'b0} + {2'd0, h});
  assign fv     = {prod, 13'd0} >> shf;
  assign mag    = (|fv[108:63]) ? SAT_MAX : {1'b0, fv[62:0]};
  assign shp    = 6'd32 - {1'b0, h};
  assign mul_p  = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ds[c] = {pi[c][31], pi[c]} - {pj[c][31], pj[c]};
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      P_SQ: begin
        mul_a = ad[cnt[1:0]];
        mul_b = ad[cnt[1:0]];
      end
      P_MUL: begin
        case (cnt[2:0])
          3'd0: begin mul_a = q;  mul_b = q; end
          3'd1: begin mul_a = t;  mul_b = q; end
          3'd2: begin mul_a = mj; mul_b = q; end
          3'd3: begin mul_a = mi; mul_b = q; end
          3'd4: begin mul_a = mj; mul_b = u; end
          default: begin mul_a = mi; mul_b = u; end
        endcase
      end
      P_FLO: begin
        mul_a = fa[31:0];
        mul_b = ad[fcc];
      end
      P_FHI: begin
        mul_a = fa[63:32];
        mul_b = ad[fcc];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      P_IDLE:  if (start) state_next = P_SUB;
      P_SUB:   state_next = P_SQ;
      P_SQ:    if (cnt == 5'd2) state_next = P_R;
      P_R:     state_next = (r_calc == '0) ? P_DONE : P_NORM;
      P_NORM:  if (r[63:62] != 2'b00) state_next = P_SQRT;
      P_SQRT:  if (cnt == 5'd31) state_next = P_DIV;
      P_DIV:   if (cnt == 5'd31) state_next = P_MUL;
      P_MUL:   if (cnt == 5'd5) state_next = P_FLO;
      P_FLO:   state_next = P_FHI;
      P_FHI:   state_next = P_FADD;
      P_FADD:  state_next = P_FSH;
      P_FSH:   state_next = (fc == 3'd5) ? P_POT : P_FLO;
      P_POT:   state_next = P_DONE;
      P_DONE:  state_next = P_IDLE;
      default: state_next = P_IDLE;
    endcase
  end

  always_comb begin
    done      = (state == P_DONE);
    res.skip  = skip;
    res.pot_i = pot_i;
    res.pot_j = pot_j;
    res.acc_i = acc_i;
    res.acc_j = acc_j;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      cnt   <= '0;
      fc    <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 5'd1;
      end
      if (state == P_SUB) begin
        fc <= '0;
      end else if (state == P_FSH) begin
        fc <= fc + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      P_IDLE: begin
        pi  <= pos_i;
        pj  <= pos_j;
        mi  <= mass_i;
        mj  <= mass_j;
        eps <= eps2;
      end
      P_SUB: begin
        for (int c = 0; c < 3; c++) begin
          neg[c] <= ds[c][32];
          ad[c]  <= ds[c][32] ? 32'(-ds[c]) : ds[c][31:0];
        end
        sum <= '0;
      end
      P_SQ: sum <= sum + {2'd0, mul_p};
      P_R: begin
        r    <= r_calc;
        h    <= '0;
        skip <= (r_calc == '0);
      end
      P_NORM: begin
        if (r[63:62] == 2'b00) begin
          r <= {r[61:0], 2'b00};
          h <= h + 5'd1;
        end else begin
          num  <= r;
          root <= '0;
          bitv <= 64'h4000_0000_0000_0000;
        end
      end
      P_SQRT: begin
        if ({1'b0, num} >= rb) begin
          num  <= num - rb[63:0];
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        rem  <= 32'h7FFF_FFFF;
        q    <= '0;
      end
      P_DIV: begin
        if (rem2 >= {1'b0, root[31:0]}) begin
          rem <= 32'(rem2 - {1'b0, root[31:0]});
          q   <= {q[30:0], 1'b1};
        end else begin
          rem <= rem2[31:0];
          q   <= {q[30:0], 1'b0};
        end
      end
      P_MUL: begin
        case (cnt[2:0])
          3'd0: t <= mul_p[63:32];
          3'd1: u <= mul_p[63:32];
          3'd2: pr_j <= mul_p;
          3'd3: pr_i <= mul_p;
          3'd4: au_j <= mul_p;
          default: au_i <= mul_p;
        endcase
      end
      P_FLO: p0 <= mul_p;
      P_FHI: p1 <= mul_p;
      P_FADD: prod <= {32'd0, p0} + {p1, 32'd0};
      P_FSH: begin
        if (fc[0]) begin
          acc_j[fcc] <= neg[fcc] ? -mag : mag;
        end else begin
          acc_i[fcc] <= neg[fcc] ? mag : -mag;
        end
      end
      P_POT: begin
        pot_i <= 64'd0 - (pr_j >> shp);
        pot_j <= 64'd0 - (pr_i >> shp);
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/direct_nbody_gravity_core.sv
// ----------------------------------------------------------------------------
// direct_nbody_gravity_core
// All-pairs softened gravity over a batch of particles held in RAM.
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  tdata: pos_x, pos_y, pos_z, mass
//                                           tlast: last_particle
//   m_*       out        m_tvalid/m_tready  tdata: particle_index, acc_x,
//                                           acc_y, acc_z, potential; tlast
//   cfg_*     in         cfg_we             softening_squared
//
// Loading accepts one particle per cycle. The item marked last starts the pass:
// each pair is read, evaluated and written back, with 0 to 31 normalization
// steps followed by the bit-serial square root and reciprocal. A pair at zero
// softened distance is skipped, and each result is held on the output until it
// is accepted. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module direct_nbody_gravity_core
  import dnb_pkg::*;
#(
  parameter int MAX_PARTICLES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // pos_x, pos_y, pos_z, mass
  input  logic         s_tlast,   // last_particle
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [263:0] m_tdata,   // particle_index, acc_x, acc_y, acc_z, potential, zero pad
  output logic         m_tlast,   // last_result
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam logic [CW-1:0] MAXN = CW'(MAX_PARTICLES);

  dnb_top_state_t state, state_next;
  logic [CW-1:0] count, n, i, j, k;
  logic [MAX_PARTICLES-1:0] valid;
  logic [2:0][31:0] pos_i;
  logic [31:0] m_i, eps;
  logic [3:0][63:0] acc_i, acc_j;
  logic [263:0] out_data;
  logic out_last, out_valid;

  logic s_acc, m_acc;
  logic [CW-1:0] n_load;
  logic pos_we, acc_we, pair_start, pair_done;
  logic [AW-1:0] pos_raddr, acc_raddr, acc_waddr;
  logic [127:0] pos_rdata;
  logic [255:0] acc_rdata, acc_wdata;
  logic [3:0][63:0] acc_rd, acc_i_sum, acc_j_sum;
  logic [AW-1:0] rd_idx;
  dnb_pair_res_t pres;

  assign s_acc  = s_tvalid && s_tready;
  assign m_acc  = m_tvalid && m_tready;
  assign n_load = (count < MAXN) ? count + CW'(1) : count;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

  always_comb begin
    unique case (state)
      T_ROW_LAT: rd_idx = i[AW-1:0];
      T_PAIR_GO: rd_idx = j[AW-1:0];
      default:   rd_idx = k[AW-1:0];
    endcase
    acc_rd = valid[rd_idx] ? acc_rdata : '0;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_i_sum[c] = sat_add(acc_i[c], pres.acc_i[c]);
      acc_j_sum[c] = sat_add(acc_j[c], pres.acc_j[c]);
    end
    acc_i_sum[3] = sat_add(acc_i[3], pres.pot_i);
    acc_j_sum[3] = sat_add(acc_j[3], pres.pot_j);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      T_LOAD:      if (s_acc && s_tlast) state_next = (n_load > CW'(1)) ? T_ROW_RD : T_OUT_RD;
      T_ROW_RD:    state_next = T_ROW_LAT;
      T_ROW_LAT:   state_next = T_PAIR_RD;
      T_PAIR_RD:   state_next = T_PAIR_GO;
      T_PAIR_GO:   state_next = T_PAIR_WAIT;
      T_PAIR_WAIT: if (pair_done) state_next = T_PAIR_WB;
      T_PAIR_WB:   state_next = (j + CW'(1) == n) ? T_ROW_WB : T_PAIR_RD;
      T_ROW_WB:    state_next = (i + CW'(2) < n) ? T_ROW_RD : T_OUT_RD;
      T_OUT_RD:    state_next = T_OUT_LAT;
      T_OUT_LAT:   state_next = T_OUT_SEND;
      T_OUT_SEND:  if (m_acc) state_next = (k + CW'(1) == n) ? T_LOAD : T_OUT_RD;
      default:     state_next = T_LOAD;
    endcase
  end

  always_comb begin
    s_tready   = (state == T_LOAD);
    pos_we     = s_acc && (count < MAXN);
    pair_start = (state == T_PAIR_GO);
    pos_raddr  = (state == T_ROW_RD) ? i[AW-1:0] : j[AW-1:0];
    unique case (state)
      T_ROW_RD:  acc_raddr = i[AW-1:0];
      T_PAIR_RD: acc_raddr = j[AW-1:0];
      default:   acc_raddr = k[AW-1:0];
    endcase
    acc_we    = (state == T_PAIR_WB) || (state == T_ROW_WB);
    acc_waddr = (state == T_ROW_WB) ? i[AW-1:0] : j[AW-1:0];
    if (state == T_ROW_WB) begin
      acc_wdata = acc_i;
    end else begin
      acc_wdata = pres.skip ? acc_j : acc_j_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_LOAD;
      count     <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
      eps       <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        eps <= cfg_wdata;
      end
      if (s_acc) begin
        count <= n_load;
        if (s_tlast) begin
          valid <= '0;
        end
      end
      if (acc_we) begin
        valid[acc_waddr] <= 1'b1;
      end
      if (state == T_OUT_LAT) begin
        out_valid <= 1'b1;
      end else if (m_acc) begin
        out_valid <= 1'b0;
        if (k + CW'(1) == n) begin
          count <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      T_LOAD: begin
        if (s_acc && s_tlast) begin
          n <= n_load;
          i <= '0;
          k <= '0;
        end
      end
      T_ROW_LAT: begin
        pos_i <= pos_rdata[95:0];
        m_i   <= pos_rdata[127:96];
        acc_i <= acc_rd;
        j     <= i + CW'(1);
      end
      T_PAIR_GO: acc_j <= acc_rd;
      T_PAIR_WB: begin
        if (!pres.skip) begin
          acc_i <= acc_i_sum;
        end
        j <= j + CW'(1);
      end
      T_ROW_WB: i <= i + CW'(1);
      T_OUT_LAT: begin
        out_data <= {2'b00, acc_rd[3], acc_rd[2], acc_rd[1], acc_rd[0], 6'(k)};
        out_last <= (k + CW'(1) == n);
      end
      T_OUT_SEND: if (m_acc) k <= k + CW'(1);
      default: ;
    endcase
  end

  dnb_ram #(.WIDTH(128), .DEPTH(MAX_PARTICLES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (count[AW-1:0]),
    .wdata (s_tdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  dnb_ram #(.WIDTH(256), .DEPTH(MAX_PARTICLES)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  dnb_pair u_pair (
    .clk    (clk),
    .rst    (rst),
    .start  (pair_start),
    .pos_i  (pos_i),
    .mass_i (m_i),
    .pos_j  (pos_rdata[95:0]),
    .mass_j (pos_rdata[127:96]),
    .eps2   (eps),
    .done   (pair_done),
    .res    (pres)
  );

`ifndef SYNTH
  a_load_out_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input taken while a result is pending");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAXN) else $error("particle count beyond store depth");
  a_pair_done: assert property (@(posedge clk) disable iff (rst)
    pair_done |-> (state == T_PAIR_WAIT)) else $error("pair result while not waiting");
  a_start_once: assert property (@(posedge clk) disable iff (rst)
    pair_start |=> !pair_start) else $error("pair unit started twice in a row");
`endif

endmodule
